FILE: design/mono_page_buffer_draw_engine_macros.svh
// Assertion macros for the monochrome page buffer draw engine.
`ifndef MONO_PAGE_BUFFER_DRAW_ENGINE_MACROS_SVH
`define MONO_PAGE_BUFFER_DRAW_ENGINE_MACROS_SVH

`ifndef SYNTHESIS

`define MPBDE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpbde assertion failed");

`define MPBDE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpbde assertion failed");

`else

`define MPBDE_ASSERT_SAME(label, clk, rst, ante, cons)

`define MPBDE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/mpbde_pkg.sv
// Shared types and constants for the page buffer draw engine.
`default_nettype none

package mpbde_pkg;

   localparam int PAGE_ROWS  = 8;
   localparam int PAGE_SHIFT = 3;
   localparam int COORD_W    = 7;
   localparam int CROSS_ARM  = 2;

   typedef enum logic [1:0] {
      CMD_CROSS = 2'd0,
      CMD_RECT  = 2'd1,
      CMD_FILL  = 2'd2,
      CMD_READ  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_SEG,
      ST_WR,
      ST_FILL,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic capture;
      logic seg_first;
      logic seg_next;
      logic pix_rd;
      logic pix_wr;
      logic pix_step;
      logic byte_rd;
      logic sweep_wr;
      logic sweep_fill;
   } dp_cmd_type;

   typedef struct packed {
      cmd_type cmd;
      logic    cmd_ok;
      logic    seg_empty;
      logic    seg_last;
      logic    pix_last;
      logic    sweep_last;
   } dp_stat_type;

endpackage

`default_nettype wire

FILE: design/mpbde_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mpbde_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 384
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: design/mpbde_ctrl.sv
// Command sequencer for the page buffer draw engine.
`default_nettype none

module mpbde_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire mpbde_pkg::dp_stat_type dp_stat,
   output mpbde_pkg::dp_cmd_type       dp_cmd,
   output logic                        busy,
   output logic                        rsp_strobe
);

   import mpbde_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (dp_stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (start) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            unique case (dp_stat.cmd)
               CMD_FILL: state_in = ST_FILL;
               CMD_READ: state_in = ST_RESP;
               default:  state_in = dp_stat.cmd_ok ? ST_SEG : ST_RESP;
            endcase
         end
         ST_SEG: begin
            if (!dp_stat.seg_empty) begin
               state_in = ST_WR;
            end else if (dp_stat.seg_last) begin
               state_in = ST_RESP;
            end
         end
         ST_WR: begin
            if (dp_stat.pix_last && dp_stat.seg_last) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SEG;
            end
         end
         ST_FILL: begin
            if (dp_stat.sweep_last) state_in = ST_RESP;
         end
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd     = '0;
      busy       = 1'b1;
      rsp_strobe = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            dp_cmd.sweep_wr = 1'b1;
         end
         ST_IDLE: begin
            busy           = 1'b0;
            dp_cmd.capture = start;
         end
         ST_DECODE: begin
            unique case (dp_stat.cmd)
               CMD_FILL: ;
               CMD_READ: dp_cmd.byte_rd = 1'b1;
               default:  dp_cmd.seg_first = dp_stat.cmd_ok;
            endcase
         end
         ST_SEG: begin
            dp_cmd.pix_rd   = !dp_stat.seg_empty;
            dp_cmd.seg_next = dp_stat.seg_empty && !dp_stat.seg_last;
         end
         ST_WR: begin
            dp_cmd.pix_wr   = 1'b1;
            dp_cmd.pix_step = !dp_stat.pix_last;
            dp_cmd.seg_next = dp_stat.pix_last && !dp_stat.seg_last;
         end
         ST_FILL: begin
            dp_cmd.sweep_wr   = 1'b1;
            dp_cmd.sweep_fill = 1'b1;
         end
         ST_RESP: begin
            rsp_strobe = 1'b1;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

FILE: design/mpbde_dp.sv
// Request registers, line walker, sweep counter and frame store.
`default_nettype none

module mpbde_dp #(
   parameter int COLUMNS = 64,
   parameter int ROWS    = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire mpbde_pkg::dp_cmd_type dp_cmd,
   output mpbde_pkg::dp_stat_type     dp_stat,
   input  wire logic [1:0]            req_command,
   input  wire logic [5:0]            req_x_first,
   input  wire logic [5:0]            req_y_first,
   input  wire logic [5:0]            req_x_second,
   input  wire logic [5:0]            req_y_second,
   input  wire logic [7:0]            req_fill_value,
   input  wire logic [2:0]            req_read_page,
   output logic                       rsp_accepted,
   output logic [7:0]                 rsp_read_data
);

   import mpbde_pkg::*;

   localparam int PAGES = (ROWS + PAGE_ROWS - 1) / PAGE_ROWS;
   localparam int DEPTH = PAGES * COLUMNS;
   localparam int AW    = $clog2(DEPTH);

   typedef struct packed {
      logic               vert;
      logic [COORD_W-1:0] fix;
      logic [COORD_W-1:0] first;
      logic [COORD_W-1:0] last;
   } seg_type;

   function automatic seg_type seg_desc(input cmd_type cmd, input logic [1:0] seg,
                                        input logic [COORD_W-1:0] xa,
                                        input logic [COORD_W-1:0] ya,
                                        input logic [COORD_W-1:0] xb,
                                        input logic [COORD_W-1:0] yb);
      seg_type d;
      if (cmd == CMD_CROSS) begin
         d.vert  = seg[0];
         d.fix   = seg[0] ? xa : ya;
         d.first = (seg[0] ? ya : xa) - COORD_W'(CROSS_ARM);
         d.last  = (seg[0] ? ya : xa) + COORD_W'(CROSS_ARM);
      end else begin
         d.vert  = seg[1];
         d.fix   = seg[1] ? (seg[0] ? xb : xa) : (seg[0] ? yb : ya);
         d.first = seg[1] ? ya : xa;
         d.last  = seg[1] ? yb : xb;
      end
      return d;
   endfunction

   cmd_type             cmd_ff;
   logic [5:0]          xa_ff;
   logic [5:0]          ya_ff;
   logic [5:0]          xb_ff;
   logic [5:0]          yb_ff;
   logic [7:0]          fv_ff;
   logic [2:0]          pg_ff;
   logic [1:0]          seg_ff;
   logic [COORD_W-1:0]  cur_ff;
   logic [AW-1:0]       sweep_ff;

   logic [COORD_W-1:0]  xa_e;
   logic [COORD_W-1:0]  ya_e;
   logic [COORD_W-1:0]  xb_e;
   logic [COORD_W-1:0]  yb_e;
   seg_type             seg_cur;
   seg_type             seg_nxt;
   seg_type             seg_zero;
   logic                cmd_ok;
   logic [COORD_W-1:0]  pix_col;
   logic [COORD_W-1:0]  pix_row;
   logic                pix_in;
   logic [AW-1:0]       pix_addr;
   logic [AW-1:0]       byte_addr;
   logic [7:0]          pix_mask;
   logic                ram_wr_en;
   logic [AW-1:0]       ram_wr_addr;
   logic [7:0]          ram_wr_data;
   logic                ram_rd_en;
   logic [AW-1:0]       ram_rd_addr;
   logic [7:0]          ram_rd_data;

   assign xa_e = COORD_W'(xa_ff);
   assign ya_e = COORD_W'(ya_ff);
   assign xb_e = COORD_W'(xb_ff);
   assign yb_e = COORD_W'(yb_ff);

   assign seg_cur  = seg_desc(cmd_ff, seg_ff, xa_e, ya_e, xb_e, yb_e);
   assign seg_nxt  = seg_desc(cmd_ff, seg_ff + 2'd1, xa_e, ya_e, xb_e, yb_e);
   assign seg_zero = seg_desc(cmd_ff, 2'd0, xa_e, ya_e, xb_e, yb_e);

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff <= cmd_type'(req_command);
         xa_ff  <= req_x_first;
         ya_ff  <= req_y_first;
         xb_ff  <= req_x_second;
         yb_ff  <= req_y_second;
         fv_ff  <= req_fill_value;
         pg_ff  <= req_read_page;
      end
      if (dp_cmd.seg_first) begin
         seg_ff <= 2'd0;
         cur_ff <= seg_zero.first;
      end else if (dp_cmd.seg_next) begin
         seg_ff <= seg_ff + 2'd1;
         cur_ff <= seg_nxt.first;
      end else if (dp_cmd.pix_step) begin
         cur_ff <= cur_ff + COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else if (dp_cmd.capture) begin
         sweep_ff <= '0;
      end else if (dp_cmd.sweep_wr) begin
         sweep_ff <= sweep_ff + AW'(1);
      end
   end

   always_comb begin
      unique case (cmd_ff)
         CMD_CROSS: cmd_ok = (32'(xa_ff) >= CROSS_ARM) && (32'(xa_ff) + CROSS_ARM < COLUMNS) &&
                             (32'(ya_ff) >= CROSS_ARM) && (32'(ya_ff) + CROSS_ARM < ROWS);
         CMD_RECT:  cmd_ok = (xa_ff != 6'd0) && (32'(xb_ff) + 1 < COLUMNS) &&
                             (ya_ff != 6'd0) && (32'(yb_ff) + 1 < ROWS);
         CMD_FILL:  cmd_ok = 1'b1;
         CMD_READ:  cmd_ok = (32'(pg_ff) < PAGES) && (32'(xa_ff) < COLUMNS);
         default:   cmd_ok = 1'b0;
      endcase
   end

   assign pix_col   = seg_cur.vert ? seg_cur.fix : cur_ff;
   assign pix_row   = seg_cur.vert ? cur_ff : seg_cur.fix;
   assign pix_in    = (32'(pix_row) < ROWS) && (32'(pix_col) < COLUMNS);
   assign pix_addr  = AW'(32'(pix_row[COORD_W-1:PAGE_SHIFT]) * COLUMNS + 32'(pix_col));
   assign byte_addr = AW'(32'(pg_ff) * COLUMNS + 32'(xa_ff));
   assign pix_mask  = 8'b1 << pix_row[PAGE_SHIFT-1:0];

   always_comb begin
      ram_wr_en   = (dp_cmd.pix_wr && pix_in) || dp_cmd.sweep_wr;
      ram_wr_addr = pix_addr;
      ram_wr_data = ram_rd_data | pix_mask;
      if (dp_cmd.sweep_wr) begin
         ram_wr_addr = sweep_ff;
         ram_wr_data = dp_cmd.sweep_fill ? fv_ff : 8'd0;
      end
   end

   assign ram_rd_en   = dp_cmd.pix_rd || dp_cmd.byte_rd;
   assign ram_rd_addr = dp_cmd.byte_rd ? byte_addr : pix_addr;

   mpbde_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_frame_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      dp_stat.cmd        = cmd_ff;
      dp_stat.cmd_ok     = cmd_ok;
      dp_stat.seg_empty  = cur_ff > seg_cur.last;
      dp_stat.seg_last   = (cmd_ff == CMD_CROSS) ? (seg_ff == 2'd1) : (seg_ff == 2'd3);
      dp_stat.pix_last   = cur_ff == seg_cur.last;
      dp_stat.sweep_last = sweep_ff == AW'(DEPTH - 1);
   end

   assign rsp_accepted  = cmd_ok;
   assign rsp_read_data = (cmd_ff == CMD_READ && cmd_ok) ? ram_rd_data : 8'd0;

endmodule

`default_nettype wire

FILE: design/mono_page_buffer_draw_engine.sv
// Top level of the monochrome page buffer draw engine.
//
//   Channel   Ports                          Transfer
//   request   start, busy, req_*             start high while busy low
//   response  rsp_strobe, rsp_*              every cycle rsp_strobe is high
//
// A read or a rejected draw goes from decode straight to the response,
// a fill sweeps the whole store and a draw walks each edge. Each pixel
// is a read-modify-write of its byte through the one read and one write
// port of the frame store.
// After reset the block clears the store, one byte a cycle, all
// PAGES*COLUMNS bytes (384 by default) with busy high.
// The receiver cannot stall: the result shows for one cycle, then busy drops.
`default_nettype none
`include "mono_page_buffer_draw_engine_macros.svh"

module mono_page_buffer_draw_engine #(
   parameter int COLUMNS = 64,
   parameter int ROWS    = 48
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic [1:0] req_command,
   input  wire logic [5:0] req_x_first,
   input  wire logic [5:0] req_y_first,
   input  wire logic [5:0] req_x_second,
   input  wire logic [5:0] req_y_second,
   input  wire logic [7:0] req_fill_value,
   input  wire logic [2:0] req_read_page,
   output logic            rsp_strobe,
   output logic            rsp_accepted,
   output logic [7:0]      rsp_read_data
);

   import mpbde_pkg::*;

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;

   mpbde_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .dp_stat    (dp_stat),
      .dp_cmd     (dp_cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   mpbde_dp #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .dp_stat        (dp_stat),
      .req_command    (req_command),
      .req_x_first    (req_x_first),
      .req_y_first    (req_y_first),
      .req_x_second   (req_x_second),
      .req_y_second   (req_y_second),
      .req_fill_value (req_fill_value),
      .req_read_page  (req_read_page),
      .rsp_accepted   (rsp_accepted),
      .rsp_read_data  (rsp_read_data)
   );

   `MPBDE_ASSERT_SAME(a_strobe_while_busy, clock, reset, rsp_strobe, busy)
   `MPBDE_ASSERT_NEXT(a_busy_after_start, clock, reset, start && !busy, busy)
   `MPBDE_ASSERT_NEXT(a_idle_after_strobe, clock, reset, rsp_strobe, !busy)
   `MPBDE_ASSERT_SAME(a_data_if_ok, clock, reset, rsp_strobe && rsp_read_data != 8'd0, rsp_accepted)

endmodule

`default_nettype wire
